/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/rtcalm_pkg.sv */
package rtcalm_pkg;

    localparam int unsigned WindowBytes = 4096;
    localparam int unsigned WinCmpW     = 17;

    localparam logic [19:0] NsPerTickReset = 20'd10;
    localparam logic [63:0] TimeSetMax     = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register index = offset[4:2]
    typedef enum logic [2:0] {
        REG_TIME_LOW        = 3'd0,
        REG_TIME_HIGH       = 3'd1,
        REG_ALARM_LOW       = 3'd2,
        REG_ALARM_HIGH      = 3'd3,
        REG_IRQ_ENABLED     = 3'd4,
        REG_CLEAR_ALARM     = 3'd5,
        REG_ALARM_STATUS    = 3'd6,
        REG_CLEAR_INTERRUPT = 3'd7
    } reg_sel_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] offset;
        logic        word_access;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fault;
        logic        irq_out;
    } out_item_t;

endpackage

/* sv/rtcalm_in_reg.sv */
module rtcalm_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rtcalm_pkg::in_item_t in_data,
    output logic                in_stall,
    input  logic                take,
    output logic                item_valid,
    output rtcalm_pkg::in_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    rtcalm_pkg::in_item_t item_reg;
    logic                 load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/rtcalm_core.sv */
module rtcalm_core
#(
    parameter int unsigned WINDOW_BYTES = rtcalm_pkg::WindowBytes
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [19:0]          ns_per_tick,
    input  logic                 item_valid,
    input  rtcalm_pkg::in_item_t item,
    output logic                 take,
    output logic                 out_valid,
    output rtcalm_pkg::out_item_t out_data,
    input  logic                 out_stall
);

    logic [63:0] time_reg,          time_next;
    logic [31:0] read_high_reg,     read_high_next;
    logic [31:0] stg_time_high_reg, stg_time_high_next;
    logic [31:0] stg_alarm_high_reg, stg_alarm_high_next;
    logic [63:0] alarm_reg,         alarm_next;
    logic        armed_reg,         armed_next;
    logic        irq_en_reg,        irq_en_next;
    logic        pending_reg,       pending_next;
    logic        out_valid_reg,     out_valid_next;
    rtcalm_pkg::out_item_t out_item_reg;

    logic [64:0] tick_sum;
    logic [63:0] tick_time;
    logic [63:0] set_value;
    logic        bus_op;
    logic        bad_access;
    logic        mapped;
    logic [31:0] rd_value;
    rtcalm_pkg::reg_sel_t sel;

    assign take           = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = take ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    assign tick_sum   = {1'b0, time_reg} + {45'd0, ns_per_tick};
    assign tick_time  = tick_sum[64] ? {64{1'b1}} : tick_sum[63:0];
    assign set_value  = {stg_time_high_reg, item.write_data};
    assign bus_op     = (item.op == rtcalm_pkg::OP_READ) || (item.op == rtcalm_pkg::OP_WRITE);
    assign bad_access = !item.word_access || (item.offset[1:0] != 2'b00);
    assign mapped     = ({5'd0, item.offset} < rtcalm_pkg::WinCmpW'(WINDOW_BYTES))
                        && (item.offset[11:5] == 7'd0);
    assign sel        = rtcalm_pkg::reg_sel_t'(item.offset[4:2]);

    always_comb
    begin
        time_next           = time_reg;
        read_high_next      = read_high_reg;
        stg_time_high_next  = stg_time_high_reg;
        stg_alarm_high_next = stg_alarm_high_reg;
        alarm_next          = alarm_reg;
        armed_next          = armed_reg;
        irq_en_next         = irq_en_reg;
        pending_next        = pending_reg;
        rd_value            = 32'd0;
        if (item.op == rtcalm_pkg::OP_TICK)
        begin
            time_next = tick_time;
            if (armed_reg && (tick_time >= alarm_reg))
            begin
                armed_next   = 1'b0;
                pending_next = irq_en_reg;
            end
        end
        else if (bus_op && !bad_access && mapped)
        begin
            if (item.op == rtcalm_pkg::OP_READ)
            begin
                case (sel)
                    rtcalm_pkg::REG_TIME_LOW:
                    begin
                        read_high_next = time_reg[63:32];
                        rd_value       = time_reg[31:0];
                    end
                    rtcalm_pkg::REG_TIME_HIGH:    rd_value = read_high_reg;
                    rtcalm_pkg::REG_ALARM_LOW:    rd_value = alarm_reg[31:0];
                    rtcalm_pkg::REG_ALARM_HIGH:   rd_value = alarm_reg[63:32];
                    rtcalm_pkg::REG_IRQ_ENABLED:  rd_value = {31'd0, irq_en_reg};
                    rtcalm_pkg::REG_ALARM_STATUS: rd_value = {31'd0, armed_reg};
                    default:                      rd_value = 32'd0;
                endcase
            end
            else
            begin
                case (sel)
                    rtcalm_pkg::REG_TIME_LOW:
                    begin
                        time_next = set_value[63] ? rtcalm_pkg::TimeSetMax : set_value;
                    end
                    rtcalm_pkg::REG_TIME_HIGH:  stg_time_high_next = item.write_data;
                    rtcalm_pkg::REG_ALARM_LOW:
                    begin
                        alarm_next   = {stg_alarm_high_reg, item.write_data};
                        armed_next   = 1'b1;
                        pending_next = 1'b0;
                    end
                    rtcalm_pkg::REG_ALARM_HIGH: stg_alarm_high_next = item.write_data;
                    rtcalm_pkg::REG_IRQ_ENABLED:
                    begin
                        irq_en_next = |item.write_data;
                        if (!(|item.write_data))
                        begin
                            pending_next = 1'b0;
                        end
                    end
                    rtcalm_pkg::REG_CLEAR_ALARM:
                    begin
                        if (|item.write_data)
                        begin
                            armed_next   = 1'b0;
                            pending_next = 1'b0;
                        end
                    end
                    rtcalm_pkg::REG_CLEAR_INTERRUPT:
                    begin
                        if (|item.write_data)
                        begin
                            pending_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg           <= 64'd0;
            read_high_reg      <= 32'd0;
            stg_time_high_reg  <= 32'd0;
            stg_alarm_high_reg <= 32'd0;
            alarm_reg          <= 64'd0;
            armed_reg          <= 1'b0;
            irq_en_reg         <= 1'b0;
            pending_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                time_reg           <= time_next;
                read_high_reg      <= read_high_next;
                stg_time_high_reg  <= stg_time_high_next;
                stg_alarm_high_reg <= stg_alarm_high_next;
                alarm_reg          <= alarm_next;
                armed_reg          <= armed_next;
                irq_en_reg         <= irq_en_next;
                pending_reg        <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg.read_data <= rd_value;
            out_item_reg.fault     <= bus_op && bad_access;
            out_item_reg.irq_out   <= pending_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

/* sv/ns_rtc_alarm_registers.sv */
// Stages: input register, then result register, which holds while out_stall is high.
// Throughput: one item per cycle while out_stall is low; the state update and the
// result share one register stage, so each item sees the state left by the item
// before it.
// Reset (rst_n low, asynchronous): time, alarm, staging and interrupt state clear,
// ns_per_tick returns to 10, both pipeline stages empty.
module ns_rtc_alarm_registers
#(
    parameter int unsigned WINDOW_BYTES = rtcalm_pkg::WindowBytes
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [19:0]           cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rtcalm_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rtcalm_pkg::out_item_t out_data
);

    logic [19:0]          ns_per_tick_reg;
    logic                 item_valid;
    logic                 take;
    rtcalm_pkg::in_item_t item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_per_tick_reg <= rtcalm_pkg::NsPerTickReset;
        end
        else if (cfg_wr_en)
        begin
            ns_per_tick_reg <= cfg_wr_data;
        end
    end

    rtcalm_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rtcalm_core
    #(
        .WINDOW_BYTES (WINDOW_BYTES)
    )
    u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ns_per_tick (ns_per_tick_reg),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .out_stall   (out_stall)
    );

endmodule

/* sv/rtcalm_checker.sv */
`include "assert_macros.svh"

module rtcalm_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input rtcalm_pkg::out_item_t out_data
);

    // input side only backs up when a result is waiting downstream
    `ASSERT_IMPLIES(a_stall_needs_full, clk, rst_n, in_stall, out_valid && out_stall)
    // a faulting access never returns data
    `ASSERT_IMPLIES(a_fault_no_data, clk, rst_n, out_valid && out_data.fault, out_data.read_data == 32'd0)
    // a stalled result item holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind ns_rtc_alarm_registers rtcalm_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* bench/tb_ns_rtc_alarm_registers.sv */
`timescale 1ns / 1ps

module tb_ns_rtc_alarm_registers;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE = 4;
    localparam int PHASE_ITEMS = 212;

    typedef enum {ACT_ITEM, ACT_CFG, ACT_DRAIN, ACT_MODE} act_kind_t;

    typedef struct {
        act_kind_t            kind;
        rtcalm_pkg::in_item_t item;
        logic [19:0]          val;
        int                   gap;
        int                   stall;
    } act_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [19:0]           cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    rtcalm_pkg::in_item_t  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    rtcalm_pkg::out_item_t out_data;

    act_t                  pend_q[$];
    rtcalm_pkg::out_item_t resp_q[$];
    int        n_items = 0;
    int        sent_cnt = 0;
    int        got_cnt = 0;
    int        quiet = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        errors = 0;
    int        stuck = 0;

    // predictor state
    logic [19:0] tick_ns = 20'd10;
    logic [63:0] now_ns = '0;
    logic [31:0] rd_hi_latch = '0;
    logic [31:0] set_hi = '0;
    logic [31:0] alm_hi = '0;
    logic [63:0] alm_ns = '0;
    logic        alm_armed = 1'b0;
    logic        irq_en = 1'b0;
    logic        irq_pend = 1'b0;

    ns_rtc_alarm_registers dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rtcalm_pkg::out_item_t rtc_respond(rtcalm_pkg::in_item_t it);
        rtcalm_pkg::out_item_t r;
        logic [64:0]           sum;
        logic [63:0]           v;
        r = '0;
        if (it.op == rtcalm_pkg::OP_TICK)
        begin
            sum = {1'b0, now_ns} + {45'd0, tick_ns};
            now_ns = sum[64] ? '1 : sum[63:0];
            if (alm_armed && now_ns >= alm_ns)
            begin
                alm_armed = 1'b0;
                irq_pend = irq_en;
            end
        end
        else if (it.op == rtcalm_pkg::OP_READ || it.op == rtcalm_pkg::OP_WRITE)
        begin
            if (!it.word_access || it.offset[1:0] != 2'b00)
                r.fault = 1'b1;
            else if (it.offset < 12'h020 && it.op == rtcalm_pkg::OP_READ)
            begin
                case (rtcalm_pkg::reg_sel_t'(it.offset[4:2]))
                    rtcalm_pkg::REG_TIME_LOW:
                    begin
                        rd_hi_latch = now_ns[63:32];
                        r.read_data = now_ns[31:0];
                    end
                    rtcalm_pkg::REG_TIME_HIGH:    r.read_data = rd_hi_latch;
                    rtcalm_pkg::REG_ALARM_LOW:    r.read_data = alm_ns[31:0];
                    rtcalm_pkg::REG_ALARM_HIGH:   r.read_data = alm_ns[63:32];
                    rtcalm_pkg::REG_IRQ_ENABLED:  r.read_data = {31'd0, irq_en};
                    rtcalm_pkg::REG_ALARM_STATUS: r.read_data = {31'd0, alm_armed};
                    default:                      r.read_data = '0;
                endcase
            end
            else if (it.offset < 12'h020)
            begin
                case (rtcalm_pkg::reg_sel_t'(it.offset[4:2]))
                    rtcalm_pkg::REG_TIME_HIGH: set_hi = it.write_data;
                    rtcalm_pkg::REG_TIME_LOW:
                    begin
                        v = {set_hi, it.write_data};
                        now_ns = (v > rtcalm_pkg::TimeSetMax) ? rtcalm_pkg::TimeSetMax : v;
                    end
                    rtcalm_pkg::REG_ALARM_HIGH: alm_hi = it.write_data;
                    rtcalm_pkg::REG_ALARM_LOW:
                    begin
                        alm_ns = {alm_hi, it.write_data};
                        alm_armed = 1'b1;
                        irq_pend = 1'b0;
                    end
                    rtcalm_pkg::REG_IRQ_ENABLED:
                    begin
                        irq_en = (it.write_data != 0);
                        if (!irq_en)
                            irq_pend = 1'b0;
                    end
                    rtcalm_pkg::REG_CLEAR_ALARM:
                    begin
                        if (it.write_data != 0)
                        begin
                            alm_armed = 1'b0;
                            irq_pend = 1'b0;
                        end
                    end
                    rtcalm_pkg::REG_CLEAR_INTERRUPT:
                    begin
                        if (it.write_data != 0)
                            irq_pend = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        r.irq_out = irq_pend;
        return r;
    endfunction

    function automatic logic [11:0] reg_ofs(rtcalm_pkg::reg_sel_t r);
        return {7'd0, r, 2'b00};
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(2))
            0:       return 32'd0;
            1:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(logic [1:0] op, logic [11:0] ofs, logic word, logic [31:0] data);
        act_t a;
        a.kind = ACT_ITEM;
        a.item.op = op;
        a.item.offset = ofs;
        a.item.word_access = word;
        a.item.write_data = data;
        a.val = '0;
        a.gap = 0;
        a.stall = 0;
        pend_q.push_back(a);
        n_items++;
    endtask

    task automatic push_ctl(act_kind_t kind, logic [19:0] val, int gap, int stall);
        act_t a;
        a.kind = kind;
        a.item = '0;
        a.val = val;
        a.gap = gap;
        a.stall = stall;
        pend_q.push_back(a);
    endtask

    task automatic bus_rd(rtcalm_pkg::reg_sel_t r);
        push_item(rtcalm_pkg::OP_READ, reg_ofs(r), 1'b1, $urandom);
    endtask

    task automatic bus_wr(rtcalm_pkg::reg_sel_t r, logic [31:0] data);
        push_item(rtcalm_pkg::OP_WRITE, reg_ofs(r), 1'b1, data);
    endtask

    task automatic tick_item();
        push_item(rtcalm_pkg::OP_TICK, 12'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic random_seq(int tsz);
        int          k;
        int          n;
        logic [31:0] t_hi;
        logic [31:0] t_lo;
        logic [63:0] al;
        k = $urandom_range(99);
        if (k < 35)
        begin
            // set time, arm alarm 0 to 12 ticks ahead, then run a random mix of mostly ticks, reads and clears
            t_hi = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
            t_lo = $urandom;
            bus_wr(rtcalm_pkg::REG_TIME_HIGH, t_hi);
            bus_wr(rtcalm_pkg::REG_TIME_LOW, t_lo);
            if ($urandom_range(2) == 0)
                bus_wr(rtcalm_pkg::REG_IRQ_ENABLED, pick_data());
            al = {t_hi, t_lo} + 64'($urandom_range(12)) * 64'(tsz);
            bus_wr(rtcalm_pkg::REG_ALARM_HIGH, al[63:32]);
            bus_wr(rtcalm_pkg::REG_ALARM_LOW, al[31:0]);
            n = $urandom_range(1, 15);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(9))
                    0: bus_rd(rtcalm_pkg::REG_ALARM_STATUS);
                    1:
                    begin
                        bus_rd(rtcalm_pkg::REG_TIME_LOW);
                        bus_rd(rtcalm_pkg::REG_TIME_HIGH);
                    end
                    2: bus_rd(rtcalm_pkg::reg_sel_t'($urandom_range(7)));
                    3:
                    begin
                        if ($urandom_range(3) == 0)
                            bus_wr(rtcalm_pkg::REG_CLEAR_INTERRUPT, pick_data());
                        else
                            tick_item();
                    end
                    4:
                    begin
                        if ($urandom_range(5) == 0)
                            bus_wr(rtcalm_pkg::REG_CLEAR_ALARM, pick_data());
                        else
                            tick_item();
                    end
                    default: tick_item();
                endcase
            end
        end
        else if (k < 55)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(1) == 0)
                begin
                    bus_rd(rtcalm_pkg::REG_TIME_LOW);
                    bus_rd(rtcalm_pkg::REG_TIME_HIGH);
                end
                else
                    bus_rd(rtcalm_pkg::reg_sel_t'($urandom_range(7)));
            end
        end
        else if (k < 75)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                tick_item();
        end
        else if (k < 88)
            bus_wr(rtcalm_pkg::reg_sel_t'($urandom_range(7)), pick_data());
        else
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_item(2'($urandom), 12'($urandom), 1'($urandom), $urandom);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        bit                   fire;
        bit                   v_next;
        bit                   cfg_next;
        rtcalm_pkg::in_item_t d_next;
        act_t                 a;
        if (rst_n)
        begin
            fire = in_valid && !in_stall;
            v_next = in_valid && !fire;
            d_next = in_data;
            cfg_next = 1'b0;
            if (fire)
            begin
                resp_q.push_back(rtc_respond(in_data));
                sent_cnt++;
            end
            if (sent_cnt == got_cnt)
                quiet++;
            else
                quiet = 0;
            if (!v_next && pend_q.size() != 0)
            begin
                a = pend_q[0];
                case (a.kind)
                    ACT_ITEM:
                    begin
                        if ($urandom_range(99) >= gap_pct)
                        begin
                            v_next = 1'b1;
                            d_next = a.item;
                            a = pend_q.pop_front();
                        end
                    end
                    ACT_CFG:
                    begin
                        if (quiet >= SETTLE)
                        begin
                            cfg_next = 1'b1;
                            cfg_wr_data <= a.val;
                            tick_ns = a.val;
                            a = pend_q.pop_front();
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (sent_cnt == got_cnt)
                            a = pend_q.pop_front();
                    end
                    default:
                    begin
                        gap_pct = a.gap;
                        stall_pct <= a.stall;
                        a = pend_q.pop_front();
                    end
                endcase
            end
            in_valid <= v_next;
            in_data <= d_next;
            cfg_wr_en <= cfg_next;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rtcalm_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (resp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: rd=%h flt=%b irq=%b",
                                 out_data.read_data, out_data.fault, out_data.irq_out);
                end
                else
                begin
                    want = resp_q.pop_front();
                    got_cnt <= got_cnt + 1;
                    if (out_data.read_data !== want.read_data || out_data.fault !== want.fault
                        || out_data.irq_out !== want.irq_out)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp rd=%h flt=%b irq=%b, got rd=%h flt=%b irq=%b",
                                     want.read_data, want.fault, want.irq_out,
                                     out_data.read_data, out_data.fault, out_data.irq_out);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            stuck <= 0;
        else
            stuck <= stuck + 1;
    end

    initial
    begin
        int tick_set[8];
        tick_set[0] = 10;
        tick_set[1] = 1;
        tick_set[2] = 1000000;
        tick_set[3] = 0;
        tick_set[4] = $urandom_range(1, 1000000);
        tick_set[5] = 10;
        tick_set[6] = 1000000;
        tick_set[7] = $urandom_range(1, 100);

        // directed
        bus_rd(rtcalm_pkg::REG_TIME_LOW);
        bus_rd(rtcalm_pkg::REG_TIME_HIGH);
        push_item(rtcalm_pkg::OP_WRITE, reg_ofs(rtcalm_pkg::REG_IRQ_ENABLED), 1'b0, 32'd1);
        push_item(rtcalm_pkg::OP_READ, 12'h009, 1'b1, 32'd0);
        push_item(OP_NONE, 12'h000, 1'b1, 32'hFFFF_FFFF);
        push_item(rtcalm_pkg::OP_READ, 12'hFFC, 1'b1, 32'd0);
        push_item(rtcalm_pkg::OP_WRITE, 12'h800, 1'b1, 32'hFFFF_FFFF);
        bus_wr(rtcalm_pkg::REG_IRQ_ENABLED, 32'd1);
        bus_wr(rtcalm_pkg::REG_ALARM_HIGH, 32'd0);
        bus_wr(rtcalm_pkg::REG_ALARM_LOW, 32'd25);
        bus_rd(rtcalm_pkg::REG_ALARM_STATUS);
        push_item(rtcalm_pkg::OP_TICK, 12'h000, 1'b0, 32'd0);
        push_item(rtcalm_pkg::OP_TICK, 12'h000, 1'b0, 32'd0);
        push_item(rtcalm_pkg::OP_TICK, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        bus_rd(rtcalm_pkg::REG_ALARM_STATUS);
        bus_wr(rtcalm_pkg::REG_ALARM_STATUS, 32'd1);
        bus_rd(rtcalm_pkg::REG_CLEAR_ALARM);
        bus_wr(rtcalm_pkg::REG_CLEAR_INTERRUPT, 32'd1);
        bus_wr(rtcalm_pkg::REG_TIME_HIGH, 32'hFFFF_FFFF);
        bus_wr(rtcalm_pkg::REG_TIME_LOW, 32'hFFFF_FFFF);
        bus_rd(rtcalm_pkg::REG_TIME_LOW);
        bus_rd(rtcalm_pkg::REG_TIME_HIGH);
        bus_wr(rtcalm_pkg::REG_CLEAR_ALARM, 32'd0);
        bus_wr(rtcalm_pkg::REG_CLEAR_ALARM, 32'd1);
        bus_wr(rtcalm_pkg::REG_IRQ_ENABLED, 32'd0);

        for (int p = 0; p < 8; p++)
        begin
            push_ctl(ACT_CFG, 20'(tick_set[p]), 0, 0);
            case (p % 4)
                0:       push_ctl(ACT_MODE, '0, 0, 0);
                1:       push_ctl(ACT_MODE, '0, 75, 0);
                2:       push_ctl(ACT_MODE, '0, 0, 75);
                default: push_ctl(ACT_MODE, '0, 25, 25);
            endcase
            n_items = 0;
            while (n_items < PHASE_ITEMS / 2)
                random_seq(tick_set[p]);
            // hold off until all results are back
            push_ctl(ACT_DRAIN, '0, 0, 0);
            while (n_items < PHASE_ITEMS)
                random_seq(tick_set[p]);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while ((pend_q.size() != 0 || in_valid || sent_cnt != got_cnt) && stuck < STUCK_LIMIT)
            @(negedge clk);
        if (stuck < STUCK_LIMIT)
            repeat (8) @(negedge clk);
        if (stuck >= STUCK_LIMIT)
            $display("FAIL ns_rtc_alarm_registers");
        else if (errors == 0 && resp_q.size() == 0)
            $display("PASS ns_rtc_alarm_registers");
        else
            $display("FAIL ns_rtc_alarm_registers");
        $finish;
    end

endmodule

/* ns_rtc_alarm_registers.f */
+incdir+sv
sv/rtcalm_pkg.sv
sv/rtcalm_in_reg.sv
sv/rtcalm_core.sv
sv/ns_rtc_alarm_registers.sv
sv/rtcalm_checker.sv
bench/tb_ns_rtc_alarm_registers.sv
